>>> sv/image_gradient_3x5_filter_core_macros.svh
`ifndef IMAGE_GRADIENT_3X5_FILTER_CORE_MACROS_SVH
`define IMAGE_GRADIENT_3X5_FILTER_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define IGF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define IGF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define IGF_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/igf_pkg.sv
package igf_pkg;

  localparam int PIX_W        = 8;
  localparam int GRAD_W       = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int WIDTH_W      = 11;
  localparam int HEIGHT_W     = 16;
  localparam int LINES_STORED = 4;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } item_kind_t;

  // One classified word handed from the front end to the back end.
  typedef struct packed {
    item_kind_t       kind;
    logic             triple;
    logic             fill;
    logic             emit;
    logic             done;
    logic             use_pix;
    logic [1:0]       wbank;
    logic [4:0][1:0]  rsel;
    logic [PIX_W-1:0] pix;
  } entry_t;

endpackage

>>> sv/igf_if.sv
interface igf_pix_if;
  logic                         valid;
  logic                         ready;
  logic [igf_pkg::PIX_W-1:0]    pixel;
  logic                         flush;

  modport source (output valid, output pixel, output flush, input ready);
  modport sink (input valid, input pixel, input flush, output ready);
endinterface

interface igf_grad_if;
  logic                              valid;
  logic                              ready;
  logic signed [igf_pkg::GRAD_W-1:0] grad_x;
  logic signed [igf_pkg::GRAD_W-1:0] grad_y;
  logic                              last_in_run;
  logic                              frame_done;

  modport source (output valid, output grad_x, output grad_y, output last_in_run,
                  output frame_done, input ready);
  modport sink (input valid, input grad_x, input grad_y, input last_in_run,
                input frame_done, output ready);
endinterface

interface igf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [igf_pkg::CFG_IDX_W-1:0]    index;
  logic [igf_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/igf_front.sv
module igf_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW        = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  igf_pix_if.sink          in_if,
  igf_cfg_if.sink          cfg_if,
  input  logic             q_full,
  output logic             q_push,
  output igf_pkg::entry_t  q_entry,
  output logic [AW-1:0]    q_addr
);

  localparam int CW   = (AW > igf_pkg::WIDTH_W) ? AW : igf_pkg::WIDTH_W;
  localparam int WMAX = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;

  logic [igf_pkg::WIDTH_W-1:0]  width_r;
  logic [igf_pkg::HEIGHT_W-1:0] height_r;
  logic [igf_pkg::HEIGHT_W-1:0] in_row_r;
  logic [AW-1:0]                in_col_r;
  logic                         pend_r;
  logic                         frow_r;
  logic [AW-1:0]                fcol_r;

  logic                         acc;
  logic                         pix_go;
  logic                         flush_go;
  logic [CW-1:0]                wlast;
  logic                         col_last;
  logic                         row_last;
  logic                         fcol_last;
  logic [CW-1:0]                fahead;
  logic [CW-1:0]                faddr;
  logic [1:0]                   hm;
  logic [igf_pkg::WIDTH_W-1:0]  wr_width;
  logic [igf_pkg::HEIGHT_W-1:0] wr_height;
  igf_pkg::entry_t              pix_e;
  igf_pkg::entry_t              fl_e;

  assign in_if.ready  = !q_full;
  assign cfg_if.ready = 1'b1;

  assign acc      = in_if.valid && in_if.ready;
  assign pix_go   = acc && !in_if.flush && !pend_r;
  assign flush_go = acc && in_if.flush && pend_r;
  assign q_push   = pix_go || flush_go;

  assign wlast     = CW'(width_r) - CW'(1);
  assign col_last  = (CW'(in_col_r) == wlast);
  assign row_last  = (in_row_r == height_r - 16'd1);
  assign fcol_last = (CW'(fcol_r) == wlast);
  assign fahead    = CW'(fcol_r) + CW'(2);
  assign faddr     = (fahead > wlast) ? wlast : fahead;
  assign hm        = height_r[1:0];

  always_comb begin
    pix_e         = '0;
    pix_e.kind    = igf_pkg::KIND_PIXEL;
    pix_e.emit    = (in_row_r >= 16'd2) && (in_col_r >= AW'(2));
    pix_e.triple  = pix_e.emit && col_last;
    pix_e.fill    = (in_col_r == '0);
    pix_e.done    = 1'b0;
    pix_e.use_pix = 1'b1;
    pix_e.wbank   = in_row_r[1:0];
    pix_e.pix     = in_if.pixel;
    for (int i = 0; i < 4; i++) begin
      pix_e.rsel[i] = (in_row_r < 16'(4 - i)) ? 2'd0 : in_row_r[1:0] + 2'(i);
    end
    pix_e.rsel[4] = 2'd0;
  end

  always_comb begin
    fl_e         = '0;
    fl_e.kind    = igf_pkg::KIND_FLUSH;
    fl_e.triple  = (fcol_r == '0);
    fl_e.fill    = (fcol_r == '0);
    fl_e.emit    = 1'b1;
    fl_e.done    = frow_r && fcol_last;
    fl_e.use_pix = 1'b0;
    fl_e.wbank   = 2'd0;
    fl_e.pix     = '0;
    if (frow_r) begin
      fl_e.rsel[0] = hm - 2'd3;
      fl_e.rsel[1] = hm - 2'd2;
      fl_e.rsel[2] = hm - 2'd1;
      fl_e.rsel[3] = hm - 2'd1;
      fl_e.rsel[4] = hm - 2'd1;
    end else begin
      fl_e.rsel[0] = (height_r == 16'd3) ? 2'd0 : hm;
      fl_e.rsel[1] = hm - 2'd3;
      fl_e.rsel[2] = hm - 2'd2;
      fl_e.rsel[3] = hm - 2'd1;
      fl_e.rsel[4] = hm - 2'd1;
    end
  end

  assign q_entry = in_if.flush ? fl_e : pix_e;
  assign q_addr  = in_if.flush ? ((fcol_r == '0) ? '0 : faddr[AW-1:0]) : in_col_r;

  always_comb begin
    wr_width = cfg_if.data[igf_pkg::WIDTH_W-1:0];
    if (wr_width < 11'd3) begin
      wr_width = 11'd3;
    end else if (wr_width > 11'(WMAX)) begin
      wr_width = 11'(WMAX);
    end
    wr_height = cfg_if.data[igf_pkg::HEIGHT_W-1:0];
    if (wr_height < 16'd3) begin
      wr_height = 16'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= igf_pkg::WIDTH_RESET;
      height_r <= igf_pkg::HEIGHT_RESET;
      in_row_r <= '0;
      in_col_r <= '0;
      pend_r   <= 1'b0;
      frow_r   <= 1'b0;
      fcol_r   <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        igf_pkg::REG_IMAGE_WIDTH: begin
          width_r <= wr_width;
        end
        igf_pkg::REG_IMAGE_HEIGHT: begin
          height_r <= wr_height;
        end
        default: begin
        end
      endcase
      if (cfg_if.index == igf_pkg::REG_IMAGE_WIDTH ||
          cfg_if.index == igf_pkg::REG_IMAGE_HEIGHT) begin
        in_row_r <= '0;
        in_col_r <= '0;
        pend_r   <= 1'b0;
        frow_r   <= 1'b0;
        fcol_r   <= '0;
      end
    end else if (pix_go) begin
      if (col_last) begin
        in_col_r <= '0;
        if (row_last) begin
          in_row_r <= '0;
          pend_r   <= 1'b1;
        end else begin
          in_row_r <= in_row_r + 16'd1;
        end
      end else begin
        in_col_r <= in_col_r + AW'(1);
      end
    end else if (flush_go) begin
      if (fcol_last) begin
        fcol_r <= '0;
        if (frow_r) begin
          frow_r <= 1'b0;
          pend_r <= 1'b0;
        end else begin
          frow_r <= 1'b1;
        end
      end else begin
        fcol_r <= fcol_r + AW'(1);
      end
    end
  end

endmodule

>>> sv/igf_queue.sv
module igf_queue #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] dout
);

  localparam int PW = $clog2(igf_pkg::QUEUE_DEPTH);
  localparam int NW = $clog2(igf_pkg::QUEUE_DEPTH + 1);

  logic [DW-1:0] mem_r [igf_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [NW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == NW'(igf_pkg::QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

endmodule

>>> sv/igf_back.sv
module igf_back #(
  parameter int MAX_WIDTH = 1024,
  parameter int AW        = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  igf_pkg::entry_t  q_entry,
  input  logic [AW-1:0]    q_addr,
  output logic             q_pop,
  igf_grad_if.source       out_if
);

  typedef struct packed {
    logic                      rep;
    logic                      fill;
    logic                      emit;
    logic                      last;
    logic                      done;
    logic                      use_pix;
    logic [4:0][1:0]           rsel;
    logic [igf_pkg::PIX_W-1:0] pix;
  } uop_t;

  function automatic logic signed [12:0] tap_diff(
    input logic [7:0] a, input logic [7:0] b, input logic [7:0] d, input logic [7:0] e);
    logic [12:0] s;
    s = {5'b0, a} - {2'b0, b, 3'b0} + {2'b0, d, 3'b0} - {5'b0, e};
    return $signed(s);
  endfunction

  function automatic logic [14:0] wsum(
    input logic [12:0] h0, input logic [12:0] h1, input logic [12:0] h2);
    return {{2{h0[12]}}, h0} + {h1[12], h1, 1'b0} + {{2{h2[12]}}, h2};
  endfunction

  logic                     adv;
  logic                     go;
  logic [1:0]               step_r;
  logic [1:0]               last_step;
  logic                     is_last;
  logic                     is_pixel;
  logic [AW-1:0]            rd_addr;
  logic                     we;
  logic                     rd_en;
  uop_t                     uop_a;

  logic [7:0]               rd_data [igf_pkg::LINES_STORED];
  logic                     b_valid_r;
  uop_t                     b_uop_r;
  logic [4:0][7:0]          col;
  logic [4:0][7:0]          hold_r;
  logic [4:0][4:0][7:0]     win_r;

  logic                     c_valid_r;
  logic                     c_last_r;
  logic                     c_done_r;
  logic signed [12:0]       hx [3];
  logic signed [12:0]       hy [3];

  logic                     d_valid_r;
  logic                     d_last_r;
  logic                     d_done_r;
  logic signed [12:0]       hx_r [3];
  logic signed [12:0]       hy_r [3];

  logic                     out_valid_r;
  logic [14:0]              gx_r;
  logic [14:0]              gy_r;
  logic                     last_r;
  logic                     done_r;

  assign adv       = !out_valid_r || out_if.ready;
  assign go        = q_valid && adv;
  assign is_pixel  = (q_entry.kind == igf_pkg::KIND_PIXEL);
  assign last_step = q_entry.triple ? 2'd2 : 2'd0;
  assign is_last   = (step_r == last_step);
  assign q_pop     = go && is_last;

  assign rd_addr = (!is_pixel && q_entry.triple) ? q_addr + AW'(step_r) : q_addr;
  assign we      = go && is_pixel && (step_r == 2'd0);

  always_comb begin
    uop_a.rep     = is_pixel && (step_r != 2'd0);
    uop_a.fill    = (step_r == 2'd0) && q_entry.fill;
    uop_a.emit    = is_pixel ? q_entry.emit : is_last;
    uop_a.last    = is_last;
    uop_a.done    = q_entry.done && is_last;
    uop_a.use_pix = q_entry.use_pix;
    uop_a.rsel    = q_entry.rsel;
    uop_a.pix     = q_entry.pix;
  end

  assign rd_en = go && !uop_a.rep;

  for (genvar b = 0; b < igf_pkg::LINES_STORED; b++) begin : g_bank
    logic [7:0] mem [MAX_WIDTH];
    logic [7:0] rdata_r;

    always_ff @(posedge clk) begin
      if (we && (q_entry.wbank == 2'(b))) begin
        mem[rd_addr] <= q_entry.pix;
      end
      if (rd_en) begin
        rdata_r <= mem[rd_addr];
      end
    end

    assign rd_data[b] = rdata_r;
  end

  always_comb begin
    if (b_uop_r.rep) begin
      col = hold_r;
    end else begin
      for (int i = 0; i < 4; i++) begin
        col[i] = rd_data[b_uop_r.rsel[i]];
      end
      col[4] = b_uop_r.use_pix ? b_uop_r.pix : rd_data[b_uop_r.rsel[4]];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hx[k] = tap_diff(win_r[0][k+1], win_r[1][k+1], win_r[3][k+1], win_r[4][k+1]);
      hy[k] = tap_diff(win_r[k+1][0], win_r[k+1][1], win_r[k+1][3], win_r[k+1][4]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_uop_r <= uop_a;
      if (b_valid_r) begin
        hold_r <= col;
        if (b_uop_r.fill) begin
          for (int j = 0; j < 5; j++) begin
            win_r[j] <= col;
          end
        end else begin
          for (int j = 0; j < 4; j++) begin
            win_r[j] <= win_r[j+1];
          end
          win_r[4] <= col;
        end
      end
      c_last_r <= b_uop_r.last;
      c_done_r <= b_uop_r.done;
      hx_r     <= hx;
      hy_r     <= hy;
      d_last_r <= c_last_r;
      d_done_r <= c_done_r;
      gx_r     <= wsum(hx_r[0], hx_r[1], hx_r[2]);
      gy_r     <= wsum(hy_r[0], hy_r[1], hy_r[2]);
      last_r   <= d_last_r;
      done_r   <= d_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 2'd0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        step_r <= is_last ? 2'd0 : step_r + 2'd1;
      end
      if (adv) begin
        b_valid_r   <= go;
        c_valid_r   <= b_valid_r && b_uop_r.emit;
        d_valid_r   <= c_valid_r;
        out_valid_r <= d_valid_r;
      end
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.grad_x      = $signed(gx_r);
  assign out_if.grad_y      = $signed(gy_r);
  assign out_if.last_in_run = last_r;
  assign out_if.frame_done  = done_r;

endmodule

>>> sv/image_gradient_3x5_filter_core.sv
// A word passes the queue and the line-store read, window, tap and output registers.
// Throughput: one word per cycle unless the queue is full or the output stalls; an output
// row's last pixel and a tail row's first flush take three results or line-store column reads.
// The input side is limited by a four-word queue ahead of the line store's shared read address.
// Reset: synchronous rst_n clears counters, queue and pipeline valids and sets 640 x 480.
// The line store is not cleared; no clearing pass runs after reset.
module image_gradient_3x5_filter_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  igf_pix_if.sink     in_if,
  igf_grad_if.source  out_if,
  igf_cfg_if.sink     cfg_if
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int EW = $bits(igf_pkg::entry_t);
  localparam int DW = EW + AW;

  logic            q_full;
  logic            q_push;
  igf_pkg::entry_t f_entry;
  logic [AW-1:0]   f_addr;
  logic            q_pop;
  logic            q_valid;
  logic [DW-1:0]   q_din;
  logic [DW-1:0]   q_dout;
  igf_pkg::entry_t b_entry;
  logic [AW-1:0]   b_addr;

  igf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .cfg_if  (cfg_if),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (f_entry),
    .q_addr  (f_addr)
  );

  assign q_din = {f_addr, f_entry};

  igf_queue #(
    .DW (DW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  assign b_entry = igf_pkg::entry_t'(q_dout[EW-1:0]);
  assign b_addr  = q_dout[DW-1 -: AW];

  igf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (b_entry),
    .q_addr  (b_addr),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

>>> sv/igf_checker.sv
`include "image_gradient_3x5_filter_core_macros.svh"

module igf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [igf_pkg::GRAD_W-1:0] grad_x,
  input logic signed [igf_pkg::GRAD_W-1:0] grad_y,
  input logic                              last_in_run,
  input logic                              frame_done
);

  `IGF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(grad_x) && $stable(grad_y) && $stable(last_in_run) && $stable(frame_done), "stalled output word changed")
  `IGF_ASSERT_IMPLIES(a_done_last, clk, rst_n, out_valid && frame_done, last_in_run, "frame end word not marked last")
  `IGF_ASSERT_ALWAYS_NEXT(a_rst_out, clk, !rst_n, !out_valid, "output valid after reset")
  `IGF_ASSERT_ALWAYS_NEXT(a_rst_in, clk, !rst_n, in_ready, "input not ready after reset")

endmodule

bind image_gradient_3x5_filter_core igf_checker u_igf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .grad_x      (out_if.grad_x),
  .grad_y      (out_if.grad_y),
  .last_in_run (out_if.last_in_run),
  .frame_done  (out_if.frame_done)
);
